// ===== sv/hbbc_pkg.sv =====
// shared constants and types of the hashed block buffer cache
`default_nettype none
package hbbc_pkg;
	localparam int DEF_NUM_BUFFERS = 32;
	localparam int DEF_NUM_BUCKETS = 13;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_FREE   = 2'd1,
		STS_UNDERFLOW = 2'd2,
		STS_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_WALK,
		S_SCAN_HEAD,
		S_SCAN_WALK,
		S_OP,
		S_UNL_P_RD,
		S_UNL_P_WR,
		S_UNL_N_RD,
		S_UNL_N_WR,
		S_PUSH_RD,
		S_PUSH_WR,
		S_DONE
	} fsm_t;
endpackage
`default_nettype wire

// ===== sv/hashed_block_buffer_cache_unit.sv =====
// top level of the hashed block buffer cache
`default_nettype none
// A pool of NUM_BUFFERS buffer descriptors kept on NUM_BUCKETS doubly linked lists,
// hashed by block number modulo the bucket count. Each input word is one command
// (get, release, pin, unpin) and gives exactly one result word. All descriptor and
// link state sits in one single-port-write, registered-read memory; only the list
// heads and tails are flip-flops. One command is worked on at a time. After reset a
// clearing pass builds the initial list before the first word is taken. A get
// first forms the bucket hash (4 bits of block number per cycle), then walks its
// list; on a miss it walks the lists from bucket 0 up, entry by entry and head by
// head, and moving the victim to another bucket adds a link read-modify-write.
// Release, pin and unpin read and update one entry, and a release may also relink
// it. A result is held in an output register so the next word can be taken while
// it waits.
module hashed_block_buffer_cache_unit
	import hbbc_pkg::*;
#(
	parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // dev_id[7:0], block_number[39:8], buffer_index[44:40]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // granted_index[4:0], hit[5], needs_read[6], status[8:7]
);
	localparam int PTR_W = $clog2(NUM_BUFFERS + 1);
	localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int BK_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SC_W  = $clog2(NUM_BUCKETS + 1);
	localparam logic [PTR_W-1:0] NIL = {PTR_W{1'b1}};
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_BUFFERS - 1);
	localparam logic [BK_W:0] NBK_C = (BK_W + 1)'(NUM_BUCKETS);
	localparam logic [SC_W-1:0] SCAN_END = SC_W'(NUM_BUCKETS);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [BK_W-1:0] bk_t;

	typedef struct packed {
		logic [7:0]       dev;
		logic [31:0]      blk;
		logic [CNT_W-1:0] cnt;
		logic             vld;
		bk_t              bkt;
		ptr_t             nxt;
		ptr_t             prv;
	} entry_t;

	// input word fields
	logic [7:0]  in_dev;
	logic [31:0] in_blk;
	logic [4:0]  in_idx;
	assign in_dev = s_tdata[7:0];
	assign in_blk = s_tdata[39:8];
	assign in_idx = s_tdata[44:40];

	// entry memory
	entry_t entry_mem [NUM_BUFFERS];
	entry_t rd_q;
	logic   mem_we;
	idx_t   mem_wa, mem_ra;
	entry_t mem_wd;

	// list heads and tails
	ptr_t first_q [NUM_BUCKETS];
	ptr_t last_q  [NUM_BUCKETS];
	logic first_we, last_we;
	bk_t  first_wa, last_wa;
	ptr_t first_wd, last_wd;

	// control and working registers
	fsm_t          state_q, state_d;
	ptr_t          clr_q;
	cmd_t          cmd_q;
	logic [7:0]    dev_q;
	logic [31:0]   blk_q;
	logic [31:0]   sh_q;
	logic [2:0]    dig_q;
	bk_t           rem_q, bk_q, unl_bk_q;
	logic [SC_W-1:0] scan_q;
	ptr_t          cur_q, hd_q;
	entry_t        word_q;
	logic [4:0]    res_grant_q;
	logic          res_hit_q, res_rd_q;
	status_t       res_st_q;
	logic [4:0]    out_grant_q;
	logic          out_hit_q, out_rd_q;
	status_t       out_st_q;
	logic          m_tvalid_q;

	// helpers
	bk_t    rem_nx;
	ptr_t   mod_head, scan_head, push_head;
	logic   match, idx_ok, out_free;
	entry_t init_word, bump_word, drop_word, victim_word;

	// 4 bits of the block number per cycle through the remainder
	always_comb begin
		logic [BK_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < 4; i++) begin
			r = {r[BK_W-1:0], sh_q[31-i]};
			if (r >= NBK_C) begin
				r = r - NBK_C;
			end
		end
		rem_nx = r[BK_W-1:0];
	end

	assign mod_head  = first_q[rem_nx];
	assign scan_head = first_q[scan_q[BK_W-1:0]];
	assign push_head = first_q[bk_q];
	assign match     = (rd_q.dev == dev_q) && (rd_q.blk == blk_q);
	assign idx_ok    = (32'(in_idx) < 32'(NUM_BUFFERS));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		init_word     = '0;
		init_word.nxt = (clr_q == '0) ? NIL : clr_q - 1'b1;
		init_word.prv = (clr_q == LAST_PTR) ? NIL : clr_q + 1'b1;
		bump_word     = rd_q;
		bump_word.cnt = rd_q.cnt + 1'b1;
		drop_word     = rd_q;
		drop_word.cnt = rd_q.cnt - 1'b1;
		victim_word     = rd_q;
		victim_word.dev = dev_q;
		victim_word.blk = blk_q;
		victim_word.cnt = CNT_W'(1);
		victim_word.vld = 1'b1;
		victim_word.bkt = bk_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory and head/tail write controls
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = cur_q[IDX_W-1:0];
		mem_wd   = word_q;
		mem_ra   = cur_q[IDX_W-1:0];
		first_we = 1'b0;
		first_wa = bk_q;
		first_wd = cur_q;
		last_we  = 1'b0;
		last_wa  = bk_q;
		last_wd  = cur_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q[IDX_W-1:0];
				mem_wd = init_word;
				if (clr_q == LAST_PTR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (cmd_t'(s_tuser) == CMD_GET) begin
						state_d = S_MOD;
					end else if (idx_ok) begin
						mem_ra  = IDX_W'(in_idx);
						state_d = S_OP;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_MOD: begin
				if (dig_q == 3'd7) begin
					mem_ra  = mod_head[IDX_W-1:0];
					state_d = (mod_head == NIL) ? S_SCAN_HEAD : S_WALK;
				end
			end
			S_WALK: begin
				if (match) begin
					if (rd_q.cnt != COUNT_MAX) begin
						mem_we        = 1'b1;
						mem_wd        = bump_word;
						mem_wd.vld    = 1'b1;
					end
					state_d = S_DONE;
				end else if (rd_q.nxt == NIL) begin
					state_d = S_SCAN_HEAD;
				end else begin
					mem_ra = rd_q.nxt[IDX_W-1:0];
				end
			end
			S_SCAN_HEAD: begin
				mem_ra = scan_head[IDX_W-1:0];
				if (scan_q == SCAN_END) begin
					state_d = S_DONE;
				end else if (scan_head != NIL) begin
					state_d = S_SCAN_WALK;
				end
			end
			S_SCAN_WALK: begin
				if (rd_q.cnt == '0) begin
					if (rd_q.bkt == bk_q) begin
						mem_we  = 1'b1;
						mem_wd  = victim_word;
						state_d = S_DONE;
					end else begin
						state_d = S_UNL_P_RD;
					end
				end else if (rd_q.nxt == NIL) begin
					state_d = S_SCAN_HEAD;
				end else begin
					mem_ra = rd_q.nxt[IDX_W-1:0];
				end
			end
			S_OP: begin
				if (cmd_q == CMD_PIN) begin
					if (rd_q.cnt != COUNT_MAX) begin
						mem_we = 1'b1;
						mem_wd = bump_word;
					end
					state_d = S_DONE;
				end else if (rd_q.cnt == '0) begin
					state_d = S_DONE;
				end else if (cmd_q == CMD_RELEASE && rd_q.cnt == CNT_W'(1)) begin
					state_d = S_UNL_P_RD;
				end else begin
					mem_we  = 1'b1;
					mem_wd  = drop_word;
					state_d = S_DONE;
				end
			end
			S_UNL_P_RD: begin
				mem_ra = word_q.prv[IDX_W-1:0];
				if (word_q.prv == NIL) begin
					first_we = 1'b1;
					first_wa = unl_bk_q;
					first_wd = word_q.nxt;
					state_d  = S_UNL_N_RD;
				end else begin
					state_d = S_UNL_P_WR;
				end
			end
			S_UNL_P_WR: begin
				mem_we     = 1'b1;
				mem_wa     = word_q.prv[IDX_W-1:0];
				mem_wd     = rd_q;
				mem_wd.nxt = word_q.nxt;
				state_d    = S_UNL_N_RD;
			end
			S_UNL_N_RD: begin
				mem_ra = word_q.nxt[IDX_W-1:0];
				if (word_q.nxt == NIL) begin
					last_we = 1'b1;
					last_wa = unl_bk_q;
					last_wd = word_q.prv;
					state_d = S_PUSH_RD;
				end else begin
					state_d = S_UNL_N_WR;
				end
			end
			S_UNL_N_WR: begin
				mem_we     = 1'b1;
				mem_wa     = word_q.nxt[IDX_W-1:0];
				mem_wd     = rd_q;
				mem_wd.prv = word_q.prv;
				state_d    = S_PUSH_RD;
			end
			S_PUSH_RD: begin
				// entry goes to the head of its bucket
				mem_we     = 1'b1;
				mem_wd     = word_q;
				mem_wd.prv = NIL;
				mem_wd.nxt = push_head;
				first_we   = 1'b1;
				mem_ra     = push_head[IDX_W-1:0];
				if (push_head == NIL) begin
					last_we = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_PUSH_WR;
				end
			end
			S_PUSH_WR: begin
				mem_we     = 1'b1;
				mem_wa     = hd_q[IDX_W-1:0];
				mem_wd     = rd_q;
				mem_wd.prv = cur_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= mem_wd;
		end
		rd_q <= entry_mem[mem_ra];
	end

	// list heads and tails, all entries start in bucket zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				first_q[b] <= (b == 0) ? LAST_PTR : NIL;
				last_q[b]  <= (b == 0) ? ptr_t'(0) : NIL;
			end
		end else begin
			if (first_we) begin
				first_q[first_wa] <= first_wd;
			end
			if (last_we) begin
				last_q[last_wa] <= last_wd;
			end
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd_q       <= cmd_t'(s_tuser);
					dev_q       <= in_dev;
					blk_q       <= in_blk;
					sh_q        <= in_blk;
					dig_q       <= '0;
					rem_q       <= '0;
					scan_q      <= '0;
					cur_q       <= ptr_t'(in_idx);
					res_grant_q <= '0;
					res_hit_q   <= 1'b0;
					res_rd_q    <= 1'b0;
					res_st_q    <= STS_OK;
				end
			end
			S_MOD: begin
				sh_q  <= {sh_q[27:0], 4'b0};
				rem_q <= rem_nx;
				dig_q <= dig_q + 1'b1;
				bk_q  <= rem_nx;
				cur_q <= mod_head;
			end
			S_WALK: begin
				if (match) begin
					res_grant_q <= 5'(cur_q);
					res_hit_q   <= 1'b1;
					if (rd_q.cnt == COUNT_MAX) begin
						res_st_q <= STS_OVERFLOW;
					end else begin
						res_rd_q <= !rd_q.vld;
					end
				end else begin
					cur_q <= rd_q.nxt;
				end
			end
			S_SCAN_HEAD: begin
				if (scan_q == SCAN_END) begin
					res_st_q <= STS_NO_FREE;
				end else if (scan_head == NIL) begin
					scan_q <= scan_q + 1'b1;
				end else begin
					cur_q <= scan_head;
				end
			end
			S_SCAN_WALK: begin
				if (rd_q.cnt == '0) begin
					res_grant_q <= 5'(cur_q);
					res_rd_q    <= 1'b1;
					word_q      <= victim_word;
					unl_bk_q    <= rd_q.bkt;
				end else if (rd_q.nxt == NIL) begin
					scan_q <= scan_q + 1'b1;
				end else begin
					cur_q <= rd_q.nxt;
				end
			end
			S_OP: begin
				if (cmd_q == CMD_PIN) begin
					if (rd_q.cnt == COUNT_MAX) begin
						res_st_q <= STS_OVERFLOW;
					end
				end else if (rd_q.cnt == '0) begin
					res_st_q <= STS_UNDERFLOW;
				end
				word_q   <= drop_word;
				unl_bk_q <= rd_q.bkt;
				bk_q     <= rd_q.bkt;
			end
			S_PUSH_RD: begin
				hd_q <= push_head;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_grant_q <= res_grant_q;
			out_hit_q   <= res_hit_q;
			out_rd_q    <= res_rd_q;
			out_st_q    <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_st_q, out_rd_q, out_hit_q, out_grant_q};

	// checks
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !s_tready)
		else $error("word taken during clearing pass");

	a_no_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_st_q == STS_NO_FREE |-> out_grant_q == '0 && !out_hit_q && !out_rd_q)
		else $error("no-free result carries an entry");

	a_read_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_rd_q |-> out_st_q == STS_OK)
		else $error("disk read flagged on an error result");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && m_tvalid && !m_tready |=> state_q == S_DONE)
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire
